>>> rtl/otm_pkg.sv
// Shared types, codes and reset constants of the one-wire temperature master.
package otm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CNT_W  = 10;
    localparam int SHORT_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [CNT_W-1:0]   RST_LOW_RESET   = 10'd503;
    localparam logic [CNT_W-1:0]   PRES_WAIT_RESET = 10'd70;
    localparam logic [CNT_W-1:0]   RST_REC_RESET   = 10'd430;
    localparam logic [CNT_W-1:0]   SLOT_HOLD_RESET = 10'd63;
    localparam logic [SHORT_W-1:0] SHORT_RESET     = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_REC      = 3'd7;

    localparam logic [1:0] OPCODE_CONVERT = 2'd1;
    localparam logic [1:0] OPCODE_READ    = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_CONVERT = 2'd1,
        OP_READ    = 2'd2
    } op_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_PRES_WAIT = 4'd2,
        PH_RST_REC   = 4'd3,
        PH_W_LOW     = 4'd4,
        PH_W_HOLD    = 4'd5,
        PH_W_REC     = 4'd6,
        PH_R_LOW     = 4'd7,
        PH_R_WAIT    = 4'd8,
        PH_R_HOLD    = 4'd9
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0]   reset_low;
        logic [CNT_W-1:0]   presence_wait;
        logic [CNT_W-1:0]   reset_recovery;
        logic [CNT_W-1:0]   slot_hold;
        logic [SHORT_W-1:0] write_low;
        logic [SHORT_W-1:0] read_low;
        logic [SHORT_W-1:0] read_sample;
        logic [SHORT_W-1:0] slot_recovery;
    } cfg_t;

    typedef struct packed {
        op_kind_t kind;
        logic     line_level;
    } front_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_seen;
        logic [7:0] temp_whole;
        logic [3:0] temp_fraction;
    } result_t;

endpackage

>>> rtl/one_wire_temperature_master.sv
// Top level of the one-wire temperature master: config registers, front, sequencer, result queue.
// A tick item waits in the front queue; its result is formed combinationally and registered in the result queue.
// Throughput: one tick item per clock while the result queue has room; each item steps the sequencer once.
// Each queue holds QUEUE_DEPTH items; either side may stall without stopping the other at once.
// Reset (rst_n low, asynchronous): queues empty, sequencer idle, reading and presence cleared,
// timing registers back to 503, 70, 430, 63, 1, 1, 1, 1.
module one_wire_temperature_master #(
    parameter int QUEUE_DEPTH = otm_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tick item side
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     operation,
    input  logic                           line_level,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic                           drive_low,
    output logic                           busy_res,
    output logic                           done_res,
    output logic                           presence_seen,
    output logic [7:0]                     temp_whole,
    output logic [3:0]                     temp_fraction,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [otm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [otm_pkg::CFG_DATA_W-1:0] cfg_data
);

    otm_pkg::cfg_t        cfg_reg;
    otm_pkg::front_item_t item;
    otm_pkg::result_t     seq_result;
    otm_pkg::result_t     out_result;
    logic                 item_valid;
    logic                 out_full;
    logic                 step;

    // Timing registers; the short ones keep only their low four bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low      <= otm_pkg::RST_LOW_RESET;
            cfg_reg.presence_wait  <= otm_pkg::PRES_WAIT_RESET;
            cfg_reg.reset_recovery <= otm_pkg::RST_REC_RESET;
            cfg_reg.slot_hold      <= otm_pkg::SLOT_HOLD_RESET;
            cfg_reg.write_low      <= otm_pkg::SHORT_RESET;
            cfg_reg.read_low       <= otm_pkg::SHORT_RESET;
            cfg_reg.read_sample    <= otm_pkg::SHORT_RESET;
            cfg_reg.slot_recovery  <= otm_pkg::SHORT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                otm_pkg::CFG_RESET_LOW:     cfg_reg.reset_low      <= cfg_data;
                otm_pkg::CFG_PRESENCE_WAIT: cfg_reg.presence_wait  <= cfg_data;
                otm_pkg::CFG_RESET_REC:     cfg_reg.reset_recovery <= cfg_data;
                otm_pkg::CFG_SLOT_HOLD:     cfg_reg.slot_hold      <= cfg_data;
                otm_pkg::CFG_WRITE_LOW:     cfg_reg.write_low      <= cfg_data[3:0];
                otm_pkg::CFG_READ_LOW:      cfg_reg.read_low       <= cfg_data[3:0];
                otm_pkg::CFG_READ_SAMPLE:   cfg_reg.read_sample    <= cfg_data[3:0];
                otm_pkg::CFG_SLOT_REC:      cfg_reg.slot_recovery  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Front: classify and hold incoming tick items.
    otm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .line_level (line_level),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    // Advance the sequencer one tick whenever an item waits and the result queue has room.
    assign step = item_valid && !out_full;

    otm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .step   (step),
        .item   (item),
        .result (seq_result)
    );

    // Result queue: holds finished results until popped.
    otm_fifo #(
        .WIDTH ($bits(otm_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (seq_result),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_result),
        .empty     (empty)
    );

    assign drive_low     = out_result.drive_low;
    assign busy_res      = out_result.busy_res;
    assign done_res      = out_result.done_res;
    assign presence_seen = out_result.presence_seen;
    assign temp_whole    = out_result.temp_whole;
    assign temp_fraction = out_result.temp_fraction;

endmodule

>>> rtl/otm_fifo.sv
// Small register-based first-in first-out queue with push/full and pop/empty sides.
module otm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = otm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/otm_front.sv
// Front end: classifies each tick item's operation and queues it for the sequencer.
module otm_front #(
    parameter int DEPTH = otm_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          operation,
    input  logic                line_level,
    output logic                item_valid,
    input  logic                item_take,
    output otm_pkg::front_item_t item
);

    otm_pkg::front_item_t in_item;
    logic                 q_empty;

    // Map opcode three (and zero) to a plain tick.
    always_comb
    begin
        in_item.line_level = line_level;
        case (operation)
            otm_pkg::OPCODE_CONVERT: in_item.kind = otm_pkg::OP_CONVERT;
            otm_pkg::OPCODE_READ:    in_item.kind = otm_pkg::OP_READ;
            default:                 in_item.kind = otm_pkg::OP_TICK;
        endcase
    end

    otm_fifo #(
        .WIDTH ($bits(otm_pkg::front_item_t)),
        .DEPTH (DEPTH)
    ) u_in_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_item),
        .full      (full),
        .pop       (item_take),
        .pop_data  (item),
        .empty     (q_empty)
    );

    assign item_valid = !q_empty;

endmodule

>>> rtl/otm_seq.sv
// Back end: tick-counted bus sequencer producing one result per tick item.
module otm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  otm_pkg::cfg_t        cfg,
    input  logic                 step,
    input  otm_pkg::front_item_t item,
    output otm_pkg::result_t     result
);

    otm_pkg::phase_t phase_reg, phase_next;
    logic [otm_pkg::CNT_W-1:0] tick_reg, tick_next, tick_inc, len;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] bit_reg, bit_next;
    logic [1:0] byte_reg, byte_next;
    logic       read_mode_reg, read_mode_next;
    logic [7:0] low_store_reg, low_store_next;
    logic [7:0] whole_reg, whole_next;
    logic [3:0] frac_reg, frac_next;
    logic       presence_reg, presence_next;
    logic       done;
    logic       timed, slot_end, start, last_bit;

    assign start    = (item.kind == otm_pkg::OP_CONVERT) || (item.kind == otm_pkg::OP_READ);
    assign tick_inc = tick_reg + 1'b1;
    assign last_bit = (bit_reg == 3'd7);
    assign timed    = (phase_reg inside {[otm_pkg::PH_RST_LOW:otm_pkg::PH_R_HOLD]});

    always_comb
    begin
        case (phase_reg)
            otm_pkg::PH_RST_LOW:   len = cfg.reset_low;
            otm_pkg::PH_PRES_WAIT: len = cfg.presence_wait;
            otm_pkg::PH_RST_REC:   len = cfg.reset_recovery;
            otm_pkg::PH_W_LOW:     len = otm_pkg::CNT_W'(cfg.write_low);
            otm_pkg::PH_W_HOLD:    len = cfg.slot_hold;
            otm_pkg::PH_W_REC:     len = otm_pkg::CNT_W'(cfg.slot_recovery);
            otm_pkg::PH_R_LOW:     len = otm_pkg::CNT_W'(cfg.read_low);
            otm_pkg::PH_R_WAIT:    len = otm_pkg::CNT_W'(cfg.read_sample);
            otm_pkg::PH_R_HOLD:    len = cfg.slot_hold;
            default:               len = otm_pkg::CNT_W'(1);
        endcase
    end

    // A zero length still lasts one tick.
    assign slot_end = (tick_inc >= ((len == '0) ? otm_pkg::CNT_W'(1) : len));

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            otm_pkg::PH_IDLE:
            begin
                if (start) phase_next = otm_pkg::PH_RST_LOW;
            end
            otm_pkg::PH_RST_LOW:
            begin
                if (slot_end) phase_next = otm_pkg::PH_PRES_WAIT;
            end
            otm_pkg::PH_PRES_WAIT:
            begin
                if (slot_end) phase_next = otm_pkg::PH_RST_REC;
            end
            otm_pkg::PH_RST_REC:
            begin
                if (slot_end) phase_next = presence_reg ? otm_pkg::PH_W_LOW : otm_pkg::PH_IDLE;
            end
            otm_pkg::PH_W_LOW:
            begin
                if (slot_end) phase_next = otm_pkg::PH_W_HOLD;
            end
            otm_pkg::PH_W_HOLD:
            begin
                if (slot_end) phase_next = otm_pkg::PH_W_REC;
            end
            otm_pkg::PH_W_REC:
            begin
                if (slot_end)
                begin
                    if (!last_bit || byte_reg == 2'd0)
                        phase_next = otm_pkg::PH_W_LOW;
                    else
                        phase_next = read_mode_reg ? otm_pkg::PH_R_LOW : otm_pkg::PH_IDLE;
                end
            end
            otm_pkg::PH_R_LOW:
            begin
                if (slot_end) phase_next = otm_pkg::PH_R_WAIT;
            end
            otm_pkg::PH_R_WAIT:
            begin
                if (slot_end) phase_next = otm_pkg::PH_R_HOLD;
            end
            otm_pkg::PH_R_HOLD:
            begin
                if (slot_end)
                    phase_next = (!last_bit || byte_reg == 2'd2) ? otm_pkg::PH_R_LOW
                                                                 : otm_pkg::PH_IDLE;
            end
            default: phase_next = otm_pkg::PH_IDLE;
        endcase
    end

    // Datapath and done
    always_comb
    begin
        tick_next      = (timed && !slot_end) ? tick_inc : '0;
        shift_next     = shift_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        read_mode_next = read_mode_reg;
        low_store_next = low_store_reg;
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        presence_next  = presence_reg;
        done           = 1'b0;
        case (phase_reg)
            otm_pkg::PH_IDLE:
            begin
                if (start)
                begin
                    read_mode_next = (item.kind == otm_pkg::OP_READ);
                    byte_next      = 2'd0;
                    bit_next       = 3'd0;
                end
            end
            otm_pkg::PH_PRES_WAIT:
            begin
                if (slot_end) presence_next = !item.line_level;
            end
            otm_pkg::PH_RST_REC:
            begin
                if (slot_end)
                begin
                    if (!presence_reg)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        shift_next = otm_pkg::CMD_SKIP_ROM;
                        bit_next   = 3'd0;
                        byte_next  = 2'd0;
                    end
                end
            end
            otm_pkg::PH_W_REC:
            begin
                if (slot_end)
                begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (!last_bit)
                    begin
                        bit_next = bit_reg + 1'b1;
                    end
                    else
                    begin
                        bit_next = 3'd0;
                        if (byte_reg == 2'd0)
                        begin
                            shift_next = read_mode_reg ? otm_pkg::CMD_READ_PAD
                                                       : otm_pkg::CMD_CONVERT;
                            byte_next  = 2'd1;
                        end
                        else if (!read_mode_reg)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            shift_next = 8'd0;
                            byte_next  = 2'd2;
                        end
                    end
                end
            end
            otm_pkg::PH_R_WAIT:
            begin
                if (slot_end) shift_next = {item.line_level, shift_reg[7:1]};
            end
            otm_pkg::PH_R_HOLD:
            begin
                if (slot_end)
                begin
                    if (!last_bit)
                    begin
                        bit_next = bit_reg + 1'b1;
                    end
                    else
                    begin
                        bit_next = 3'd0;
                        if (byte_reg == 2'd2)
                        begin
                            low_store_next = shift_reg;
                            shift_next     = 8'd0;
                            byte_next      = 2'd3;
                        end
                        else
                        begin
                            frac_next  = low_store_reg[3:0];
                            whole_next = {shift_reg[3:0], low_store_reg[7:4]};
                            done       = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Result for this tick
    always_comb
    begin
        case (phase_next)
            otm_pkg::PH_RST_LOW, otm_pkg::PH_W_LOW, otm_pkg::PH_R_LOW:
                result.drive_low = 1'b1;
            otm_pkg::PH_W_HOLD:
                result.drive_low = !shift_next[0];
            default:
                result.drive_low = 1'b0;
        endcase
        result.busy_res      = (phase_next != otm_pkg::PH_IDLE);
        result.done_res      = done;
        result.presence_seen = presence_next;
        result.temp_whole    = whole_next;
        result.temp_fraction = frac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= otm_pkg::PH_IDLE;
            tick_reg      <= '0;
            shift_reg     <= '0;
            bit_reg       <= '0;
            byte_reg      <= '0;
            read_mode_reg <= 1'b0;
            low_store_reg <= '0;
            whole_reg     <= '0;
            frac_reg      <= '0;
            presence_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            shift_reg     <= shift_next;
            bit_reg       <= bit_next;
            byte_reg      <= byte_next;
            read_mode_reg <= read_mode_next;
            low_store_reg <= low_store_next;
            whole_reg     <= whole_next;
            frac_reg      <= frac_next;
            presence_reg  <= presence_next;
        end
    end

endmodule

>>> test/otm_bus_monitor.sv
// Bus monitor for the one-wire temperature master: tracks timing writes, predicts and compares.
module otm_bus_monitor
    import otm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [1:0]            operation,
    input  logic                  line_level,
    input  logic                  empty,
    input  logic                  pop,
    input  logic                  drive_low,
    input  logic                  busy_res,
    input  logic                  done_res,
    input  logic                  presence_seen,
    input  logic [7:0]            temp_whole,
    input  logic [3:0]            temp_fraction,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output logic                  seq_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t             timing;
    phase_t           ph;
    logic [CNT_W-1:0] tick_count;
    logic [7:0]       shift_reg;
    logic [2:0]       bit_no;
    logic [2:0]       byte_no;
    logic             reading;
    logic [7:0]       low_byte;
    logic [7:0]       reading_whole;
    logic [3:0]       reading_frac;
    logic             device_seen;

    result_t          pending_outputs[$];

    // A zero count still lasts one tick.
    function automatic logic [CNT_W-1:0] phase_len(input phase_t p);
        logic [CNT_W-1:0] n;
        case (p)
            PH_RST_LOW:   n = timing.reset_low;
            PH_PRES_WAIT: n = timing.presence_wait;
            PH_RST_REC:   n = timing.reset_recovery;
            PH_W_LOW:     n = CNT_W'(timing.write_low);
            PH_W_HOLD:    n = timing.slot_hold;
            PH_W_REC:     n = CNT_W'(timing.slot_recovery);
            PH_R_LOW:     n = CNT_W'(timing.read_low);
            PH_R_WAIT:    n = CNT_W'(timing.read_sample);
            PH_R_HOLD:    n = timing.slot_hold;
            default:      n = CNT_W'(1);
        endcase
        return (n == '0) ? CNT_W'(1) : n;
    endfunction

    task automatic advance_sequencer(input logic [1:0] op, input logic line,
                                     output result_t r);
        logic finished;
        finished = 1'b0;
        if (ph == PH_IDLE) begin
            if (op == OP_CONVERT || op == OP_READ) begin
                reading    = (op == OP_READ);
                byte_no    = '0;
                bit_no     = '0;
                ph         = PH_RST_LOW;
                tick_count = '0;
            end
        end else begin
            tick_count = tick_count + 1'b1;
            if (tick_count >= phase_len(ph)) begin
                tick_count = '0;
                case (ph)
                    PH_RST_LOW:   ph = PH_PRES_WAIT;
                    PH_PRES_WAIT:
                    begin
                        device_seen = ~line;
                        ph          = PH_RST_REC;
                    end
                    PH_RST_REC:
                    begin
                        if (!device_seen) begin
                            finished = 1'b1;
                            ph       = PH_IDLE;
                        end else begin
                            shift_reg = CMD_SKIP_ROM;
                            bit_no    = '0;
                            byte_no   = '0;
                            ph        = PH_W_LOW;
                        end
                    end
                    PH_W_LOW:     ph = PH_W_HOLD;
                    PH_W_HOLD:    ph = PH_W_REC;
                    PH_W_REC:
                    begin
                        shift_reg = shift_reg >> 1;
                        if (bit_no < 3'd7) begin
                            bit_no = bit_no + 1'b1;
                            ph     = PH_W_LOW;
                        end else begin
                            bit_no = '0;
                            if (byte_no == 0) begin
                                shift_reg = reading ? CMD_READ_PAD : CMD_CONVERT;
                                byte_no   = 3'd1;
                                ph        = PH_W_LOW;
                            end else if (!reading) begin
                                finished = 1'b1;
                                ph       = PH_IDLE;
                            end else begin
                                shift_reg = '0;
                                byte_no   = 3'd2;
                                ph        = PH_R_LOW;
                            end
                        end
                    end
                    PH_R_LOW:     ph = PH_R_WAIT;
                    PH_R_WAIT:
                    begin
                        shift_reg = {line, shift_reg[7:1]};
                        ph        = PH_R_HOLD;
                    end
                    PH_R_HOLD:
                    begin
                        if (bit_no < 3'd7) begin
                            bit_no = bit_no + 1'b1;
                            ph     = PH_R_LOW;
                        end else begin
                            bit_no = '0;
                            if (byte_no == 3'd2) begin
                                low_byte  = shift_reg;
                                shift_reg = '0;
                                byte_no   = 3'd3;
                                ph        = PH_R_LOW;
                            end else begin
                                reading_frac  = low_byte[3:0];
                                reading_whole = {shift_reg[3:0], low_byte[7:4]};
                                finished      = 1'b1;
                                ph            = PH_IDLE;
                            end
                        end
                    end
                    default:      ph = PH_IDLE;
                endcase
            end
        end
        r.drive_low     = (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW) ||
                          (ph == PH_W_HOLD && !shift_reg[0]);
        r.busy_res      = (ph != PH_IDLE);
        r.done_res      = finished;
        r.presence_seen = device_seen;
        r.temp_whole    = reading_whole;
        r.temp_fraction = reading_frac;
    endtask

    task automatic check_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t predicted;
        if (!rst_n) begin
            timing        = '{RST_LOW_RESET, PRES_WAIT_RESET, RST_REC_RESET, SLOT_HOLD_RESET,
                              SHORT_RESET, SHORT_RESET, SHORT_RESET, SHORT_RESET};
            ph            = PH_IDLE;
            tick_count    = '0;
            shift_reg     = '0;
            bit_no        = '0;
            byte_no       = '0;
            reading       = 1'b0;
            low_byte      = '0;
            reading_whole = '0;
            reading_frac  = '0;
            device_seen   = 1'b0;
            mismatches    = 0;
            pending_outputs.delete();
        end else begin
            if (pop && !empty) begin
                if (pending_outputs.size() == 0) begin
                    mismatches++;
                    $display("%0t: result popped with nothing expected", $time);
                end else begin
                    predicted = pending_outputs.pop_front();
                    check_field("drive_low", predicted.drive_low, drive_low);
                    check_field("busy_res", predicted.busy_res, busy_res);
                    check_field("done_res", predicted.done_res, done_res);
                    check_field("presence_seen", predicted.presence_seen, presence_seen);
                    check_field("temp_whole", predicted.temp_whole, temp_whole);
                    check_field("temp_fraction", predicted.temp_fraction, temp_fraction);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RESET_LOW:     timing.reset_low      = cfg_data;
                    CFG_PRESENCE_WAIT: timing.presence_wait  = cfg_data;
                    CFG_RESET_REC:     timing.reset_recovery = cfg_data;
                    CFG_SLOT_HOLD:     timing.slot_hold      = cfg_data;
                    CFG_WRITE_LOW:     timing.write_low      = cfg_data[SHORT_W-1:0];
                    CFG_READ_LOW:      timing.read_low       = cfg_data[SHORT_W-1:0];
                    CFG_READ_SAMPLE:   timing.read_sample    = cfg_data[SHORT_W-1:0];
                    default:           timing.slot_recovery  = cfg_data[SHORT_W-1:0];
                endcase
            end
            if (push && !full) begin
                advance_sequencer(operation, line_level, predicted);
                pending_outputs.push_back(predicted);
            end
        end
        outstanding = pending_outputs.size();
        seq_idle    = (ph == PH_IDLE);
    end

endmodule

>>> test/tb_one_wire_temperature_master.sv
// Testbench top for the one-wire temperature master: clock, reset, tick stimulus and verdict.
module tb_one_wire_temperature_master;
    timeunit 1ns;
    timeprecision 1ps;

    import otm_pkg::*;

    // Generous ceiling on the cycle count of the whole run.
    localparam int LIMIT = 200_000;
    // Operation code 3 has no meaning and must behave as a plain tick.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_STRETCH = 150;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    logic [1:0]            operation  = OP_TICK;
    logic                  line_level = 1'b1;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    logic                  presence_seen;
    logic [7:0]            temp_whole;
    logic [3:0]            temp_fraction;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int                    mismatches;
    int                    outstanding;
    logic                  seq_idle;
    int                    cycle_count = 0;
    // Random idling on both sides; cleared for the closing stretch.
    bit                    gaps_on     = 1'b1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    one_wire_temperature_master i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .line_level    (line_level),
        .empty         (empty),
        .pop           (pop),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .presence_seen (presence_seen),
        .temp_whole    (temp_whole),
        .temp_fraction (temp_fraction),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    otm_bus_monitor i_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .line_level    (line_level),
        .empty         (empty),
        .pop           (pop),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .presence_seen (presence_seen),
        .temp_whole    (temp_whole),
        .temp_fraction (temp_fraction),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .seq_idle      (seq_idle)
    );

    // Stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: keep pop high, drop it for short random bursts.
    initial begin
        forever begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one tick item; called and returning on a falling edge. An idle burst may
    // come first. Hold the item until a rising edge sees full low.
    task automatic send_tick(input logic [1:0] op, input logic level);
        logic taken;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        push       <= 1'b1;
        operation  <= op;
        line_level <= level;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !full;
            @(negedge clk);
        end
    endtask

    // Tick until the sequencer is idle, then drain the result queue. A level above one
    // means a random line on every tick; otherwise the line is held at that level.
    task automatic settle(input int level);
        while (!seq_idle)
            send_tick(OP_TICK, (level > 1) ? 1'($urandom_range(0, 1)) : 1'(level));
        push <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Load all eight timing registers; call only while the block is idle.
    task automatic write_timing(input cfg_t c);
        write_reg(CFG_RESET_LOW, c.reset_low);
        write_reg(CFG_PRESENCE_WAIT, c.presence_wait);
        write_reg(CFG_RESET_REC, c.reset_recovery);
        write_reg(CFG_SLOT_HOLD, c.slot_hold);
        write_reg(CFG_WRITE_LOW, CFG_DATA_W'(c.write_low));
        write_reg(CFG_READ_LOW, CFG_DATA_W'(c.read_low));
        write_reg(CFG_READ_SAMPLE, CFG_DATA_W'(c.read_sample));
        write_reg(CFG_SLOT_REC, CFG_DATA_W'(c.slot_recovery));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic cfg_t make_timing(input int long_max, input int short_max);
        cfg_t c;
        c.reset_low      = CNT_W'($urandom_range(0, long_max));
        c.presence_wait  = CNT_W'($urandom_range(0, long_max));
        c.reset_recovery = CNT_W'($urandom_range(0, long_max));
        c.slot_hold      = CNT_W'($urandom_range(0, long_max));
        c.write_low      = SHORT_W'($urandom_range(0, short_max));
        c.read_low       = SHORT_W'($urandom_range(0, short_max));
        c.read_sample    = SHORT_W'($urandom_range(0, short_max));
        c.slot_recovery  = SHORT_W'($urandom_range(0, short_max));
        return c;
    endfunction

    // Mostly whole transactions: usually start one when the sequencer is idle, then tick
    // with random line levels so presence and read bits vary. Sprinkle in unused codes
    // and starts while busy, which the block must ignore.
    task automatic run_random(input int count, input bit pause_mid);
        logic [1:0] op;
        for (int k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2) begin
                // Hold off the sender until every expected result is back.
                push <= 1'b0;
                while (outstanding != 0) @(negedge clk);
                @(negedge clk);
            end
            if (seq_idle)
                op = ($urandom_range(0, 9) < 8) ?
                     ($urandom_range(0, 1) ? OP_READ : OP_CONVERT) : 2'($urandom_range(0, 3));
            else
                op = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK;
            send_tick(op, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Keep the reset value of the presence wait and of the short registers; shrink
        // the other long ones so the transactions stay short.
        write_reg(CFG_RESET_LOW, '0);
        write_reg(CFG_RESET_REC, '0);
        write_reg(CFG_SLOT_HOLD, '0);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_tick(OP_TICK, 1'b0);
        send_tick(OP_UNUSED, 1'b1);
        // Read with no device answering, then one with a device and a zero reading.
        send_tick(OP_READ, 1'b1);
        settle(1);
        send_tick(OP_READ, 1'b0);
        settle(0);

        // Every register at zero: each phase shrinks to a single tick.
        write_timing('0);
        send_tick(OP_TICK, 1'b0);
        send_tick(OP_UNUSED, 1'b1);
        // Conversion with a device answering the presence check.
        send_tick(OP_CONVERT, 1'b1);
        send_tick(OP_TICK, 1'b1);
        send_tick(OP_TICK, 1'b0);
        // Starts arriving while busy are dropped.
        send_tick(OP_READ, 1'b1);
        send_tick(OP_CONVERT, 1'b0);
        send_tick(OP_UNUSED, 1'b1);
        settle(2);
        // Read with no device: ends right after the recovery wait, reading kept.
        send_tick(OP_READ, 1'b0);
        send_tick(OP_TICK, 1'b0);
        send_tick(OP_TICK, 1'b1);
        settle(2);
        // Read of all ones, then of all zeros: both extremes of the reading.
        send_tick(OP_READ, 1'b1);
        send_tick(OP_TICK, 1'b1);
        send_tick(OP_TICK, 1'b0);
        settle(1);
        send_tick(OP_READ, 1'b1);
        send_tick(OP_TICK, 1'b1);
        send_tick(OP_TICK, 1'b0);
        settle(0);

        // Random stretch with short random timing and a full drain halfway.
        write_timing(make_timing(3, 3));
        run_random(RANDOM_STRETCH, 1'b1);
        settle(2);

        // Closing stretch with no idling on either side.
        write_timing(make_timing(4, 4));
        gaps_on = 1'b0;
        run_random(RANDOM_STRETCH, 1'b0);

        // Drain the remaining results, then allow the block's latency to pass.
        push <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
